// ===== hdl/cior_pkg.sv =====
// ----------------------------------------------------------------------------
// cior_pkg
// Shared codes for the CPU I/O register window: request types, register
// offsets and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package cior_pkg;

    localparam int REQ_W  = 3;
    localparam int IDX_W  = 5;
    localparam int BYTE_W = 8;
    localparam int LINE_W = 9;
    localparam int WORD_W = 16;
    localparam int CNT_W  = 4;
    localparam int ST_W   = 3;

    localparam logic [REQ_W-1:0] REQ_READ   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_LINE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_VBLANK = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PAD    = 3'd4;

    localparam logic [IDX_W-1:0] WR_NMITIMEN = 5'h00;
    localparam logic [IDX_W-1:0] WR_WRIO     = 5'h01;
    localparam logic [IDX_W-1:0] WR_WRMPYA   = 5'h02;
    localparam logic [IDX_W-1:0] WR_WRMPYB   = 5'h03;
    localparam logic [IDX_W-1:0] WR_WRDIVL   = 5'h04;
    localparam logic [IDX_W-1:0] WR_WRDIVH   = 5'h05;
    localparam logic [IDX_W-1:0] WR_WRDIVB   = 5'h06;
    localparam logic [IDX_W-1:0] WR_HDMAEN   = 5'h0C;

    localparam logic [IDX_W-1:0] RD_RDNMI    = 5'h10;
    localparam logic [IDX_W-1:0] RD_TIMEUP   = 5'h11;
    localparam logic [IDX_W-1:0] RD_HVBJOY   = 5'h12;
    localparam logic [IDX_W-1:0] RD_RDDIVL   = 5'h14;
    localparam logic [IDX_W-1:0] RD_RDDIVH   = 5'h15;
    localparam logic [IDX_W-1:0] RD_RDMPYL   = 5'h16;
    localparam logic [IDX_W-1:0] RD_RDMPYH   = 5'h17;
    localparam logic [IDX_W-1:0] RD_JOY1L    = 5'h18;
    localparam logic [IDX_W-1:0] RD_JOY1H    = 5'h19;
    localparam logic [IDX_W-1:0] RD_JOY2L    = 5'h1A;
    localparam logic [IDX_W-1:0] RD_JOY2H    = 5'h1B;

    localparam logic [LINE_W-1:0] VBLANK_LINE = 9'd224;
    localparam logic [BYTE_W-1:0] FLAG_BIT7   = 8'h80;
    localparam logic [BYTE_W-1:0] NMI_VERSION = 8'h02;
    localparam logic [BYTE_W-1:0] IO_RESET    = 8'hFF;
    localparam logic [WORD_W-1:0] DIV_ZERO_Q  = 16'hFFFF;

    localparam logic [CNT_W-1:0] MUL_STEPS_M1 = 4'd7;
    localparam logic [CNT_W-1:0] DIV_STEPS_M1 = 4'd15;

    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_MUL  = 3'd1;
    localparam logic [ST_W-1:0] ST_DIV  = 3'd2;
    localparam logic [ST_W-1:0] ST_DONE = 3'd3;

endpackage

`default_nettype wire

// ===== hdl/cpu_io_math_registers.sv =====
// Reads, events and plain writes go straight to ST_DONE; a multiplier start first
// runs ST_MUL (one multiplier bit per cycle, 8 steps), a divide by nonzero ST_DIV
// (one quotient bit per cycle, 16 steps). One request at a time; a result waiting
// at the output does not hold up the next request, but that one waits in ST_DONE.
// Reset (synchronous, aresetn low) clears all but the payload, io port to 0xFF.
// ----------------------------------------------------------------------------
// cpu_io_math_registers
// CPU I/O register window with bit-serial 8x8 multiplier and 16/8 divider.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_io_math_registers
    import cior_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [REQ_W-1:0]  s_req_type,
    input  wire logic [IDX_W-1:0]  s_reg_index,
    input  wire logic [BYTE_W-1:0] s_write_data,
    input  wire logic [LINE_W-1:0] s_line_number,
    input  wire logic              s_pad_port,
    input  wire logic [WORD_W-1:0] s_pad_word,
    input  wire logic              s_irq_pending,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [BYTE_W-1:0]      m_read_data,
    output logic                   m_irq_clear,
    output logic [BYTE_W-1:0]      m_int_enable,
    output logic [BYTE_W-1:0]      m_io_port,
    output logic [BYTE_W-1:0]      m_hdma_enable
);

    logic [ST_W-1:0]   state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BYTE_W-1:0] int_enable_reg, int_enable_next;
    logic [BYTE_W-1:0] io_port_reg, io_port_next;
    logic [BYTE_W-1:0] hdma_mask_reg, hdma_mask_next;
    logic [BYTE_W-1:0] mul_a_reg, mul_a_next;
    logic [WORD_W-1:0] result_reg, result_next;
    logic [WORD_W-1:0] dividend_reg, dividend_next;
    logic [BYTE_W-1:0] divisor_reg, divisor_next;
    logic [WORD_W-1:0] quotient_reg, quotient_next;
    logic [BYTE_W-1:0] rem_reg, rem_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              vblank_reg, vblank_next;
    logic [WORD_W-1:0] pad0_reg, pad0_next;
    logic [WORD_W-1:0] pad1_reg, pad1_next;
    logic [BYTE_W-1:0] pend_rd_reg, pend_rd_next;
    logic              pend_clr_reg, pend_clr_next;
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_rd_reg, m_rd_next;
    logic              m_clr_reg, m_clr_next;
    logic [BYTE_W-1:0] m_ie_reg, m_ie_next;
    logic [BYTE_W-1:0] m_io_reg, m_io_next;
    logic [BYTE_W-1:0] m_hdma_reg, m_hdma_next;

    logic              accept;
    logic              out_free;
    logic [BYTE_W:0]   mul_sum;
    logic [BYTE_W:0]   div_trial;
    logic [BYTE_W:0]   div_diff;
    logic              div_ge;
    logic [BYTE_W-1:0] rd_val;
    logic              rd_clr;

    assign s_ready       = (state_reg == ST_IDLE);
    assign accept        = s_valid && s_ready;
    assign out_free      = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_read_data   = m_rd_reg;
    assign m_irq_clear   = m_clr_reg;
    assign m_int_enable  = m_ie_reg;
    assign m_io_port     = m_io_reg;
    assign m_hdma_enable = m_hdma_reg;

    // one multiplier bit per step
    assign mul_sum = {1'b0, result_reg[WORD_W-1:BYTE_W]}
                   + (result_reg[0] ? {1'b0, mul_a_reg} : {(BYTE_W+1){1'b0}});

    // one quotient bit per step
    assign div_trial = {rem_reg, quotient_reg[WORD_W-1]};
    assign div_diff  = div_trial - {1'b0, divisor_reg};
    assign div_ge    = (div_trial >= {1'b0, divisor_reg});

    always_comb begin
        rd_val = '0;
        rd_clr = 1'b0;
        unique case (s_reg_index)
            RD_RDNMI:  rd_val = (vblank_reg ? FLAG_BIT7 : '0) | NMI_VERSION;
            RD_TIMEUP: begin
                rd_val = s_irq_pending ? FLAG_BIT7 : '0;
                rd_clr = 1'b1;
            end
            RD_HVBJOY: rd_val = (line_reg >= VBLANK_LINE) ? FLAG_BIT7 : '0;
            RD_RDDIVL: rd_val = quotient_reg[BYTE_W-1:0];
            RD_RDDIVH: rd_val = quotient_reg[WORD_W-1:BYTE_W];
            RD_RDMPYL: rd_val = result_reg[BYTE_W-1:0];
            RD_RDMPYH: rd_val = result_reg[WORD_W-1:BYTE_W];
            RD_JOY1L:  rd_val = pad0_reg[BYTE_W-1:0];
            RD_JOY1H:  rd_val = pad0_reg[WORD_W-1:BYTE_W];
            RD_JOY2L:  rd_val = pad1_reg[BYTE_W-1:0];
            RD_JOY2H:  rd_val = pad1_reg[WORD_W-1:BYTE_W];
            default:   rd_val = '0;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        int_enable_next = int_enable_reg;
        io_port_next    = io_port_reg;
        hdma_mask_next  = hdma_mask_reg;
        mul_a_next      = mul_a_reg;
        result_next     = result_reg;
        dividend_next   = dividend_reg;
        divisor_next    = divisor_reg;
        quotient_next   = quotient_reg;
        rem_next        = rem_reg;
        line_next       = line_reg;
        vblank_next     = vblank_reg;
        pad0_next       = pad0_reg;
        pad1_next       = pad1_reg;
        pend_rd_next    = pend_rd_reg;
        pend_clr_next   = pend_clr_reg;
        m_valid_next    = m_valid_reg;
        m_rd_next       = m_rd_reg;
        m_clr_next      = m_clr_reg;
        m_ie_next       = m_ie_reg;
        m_io_next       = m_io_reg;
        m_hdma_next     = m_hdma_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pend_rd_next  = '0;
                    pend_clr_next = 1'b0;
                    state_next    = ST_DONE;
                    unique case (s_req_type)
                        REQ_READ: begin
                            pend_rd_next  = rd_val;
                            pend_clr_next = rd_clr;
                            if (s_reg_index == RD_RDNMI) begin
                                vblank_next = 1'b0;
                            end
                        end
                        REQ_WRITE: begin
                            unique case (s_reg_index)
                                WR_NMITIMEN: int_enable_next = s_write_data;
                                WR_WRIO:     io_port_next    = s_write_data;
                                WR_WRMPYA:   mul_a_next      = s_write_data;
                                WR_WRMPYB: begin
                                    result_next = {{BYTE_W{1'b0}}, s_write_data};
                                    cnt_next    = MUL_STEPS_M1;
                                    state_next  = ST_MUL;
                                end
                                WR_WRDIVL: dividend_next[BYTE_W-1:0] = s_write_data;
                                WR_WRDIVH: dividend_next[WORD_W-1:BYTE_W] = s_write_data;
                                WR_WRDIVB: begin
                                    divisor_next = s_write_data;
                                    if (s_write_data == '0) begin
                                        quotient_next = DIV_ZERO_Q;
                                        result_next   = dividend_reg;
                                    end else begin
                                        quotient_next = dividend_reg;
                                        rem_next      = '0;
                                        cnt_next      = DIV_STEPS_M1;
                                        state_next    = ST_DIV;
                                    end
                                end
                                WR_HDMAEN: hdma_mask_next = s_write_data;
                                default: ;
                            endcase
                        end
                        REQ_LINE: begin
                            line_next = s_line_number;
                            if (s_line_number == '0) begin
                                vblank_next = 1'b0;
                            end
                        end
                        REQ_VBLANK: begin
                            vblank_next = 1'b1;
                            line_next   = VBLANK_LINE;
                        end
                        REQ_PAD: begin
                            if (s_pad_port) begin
                                pad1_next = s_pad_word;
                            end else begin
                                pad0_next = s_pad_word;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                result_next = {mul_sum, result_reg[BYTE_W-1:1]};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV: begin
                rem_next      = div_ge ? div_diff[BYTE_W-1:0] : div_trial[BYTE_W-1:0];
                quotient_next = {quotient_reg[WORD_W-2:0], div_ge};
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    result_next = {{BYTE_W{1'b0}},
                                   (div_ge ? div_diff[BYTE_W-1:0] : div_trial[BYTE_W-1:0])};
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_rd_next    = pend_rd_reg;
                    m_clr_next   = pend_clr_reg;
                    m_ie_next    = int_enable_reg;
                    m_io_next    = io_port_reg;
                    m_hdma_next  = hdma_mask_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            int_enable_reg <= '0;
            io_port_reg    <= IO_RESET;
            hdma_mask_reg  <= '0;
            mul_a_reg      <= '0;
            result_reg     <= '0;
            dividend_reg   <= '0;
            divisor_reg    <= '0;
            quotient_reg   <= '0;
            rem_reg        <= '0;
            line_reg       <= '0;
            vblank_reg     <= 1'b0;
            pad0_reg       <= '0;
            pad1_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            int_enable_reg <= int_enable_next;
            io_port_reg    <= io_port_next;
            hdma_mask_reg  <= hdma_mask_next;
            mul_a_reg      <= mul_a_next;
            result_reg     <= result_next;
            dividend_reg   <= dividend_next;
            divisor_reg    <= divisor_next;
            quotient_reg   <= quotient_next;
            rem_reg        <= rem_next;
            line_reg       <= line_next;
            vblank_reg     <= vblank_next;
            pad0_reg       <= pad0_next;
            pad1_reg       <= pad1_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        pend_rd_reg  <= pend_rd_next;
        pend_clr_reg <= pend_clr_next;
        m_rd_reg     <= m_rd_next;
        m_clr_reg    <= m_clr_next;
        m_ie_reg     <= m_ie_next;
        m_io_reg     <= m_io_next;
        m_hdma_reg   <= m_hdma_next;
    end

endmodule

`default_nettype wire

// ===== sim/cpu_io_math_registers_checker.sv =====
// ----------------------------------------------------------------------------
// cpu_io_math_registers_checker
// Watches both channels of the CPU I/O register window. On each accepted
// request it works out the reply from its own copy of the window state, and
// it compares each accepted reply, field by field, with the oldest one owed.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_io_math_registers_checker
    import cior_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic [REQ_W-1:0]  s_req_type,
    input  wire logic [IDX_W-1:0]  s_reg_index,
    input  wire logic [BYTE_W-1:0] s_write_data,
    input  wire logic [LINE_W-1:0] s_line_number,
    input  wire logic              s_pad_port,
    input  wire logic [WORD_W-1:0] s_pad_word,
    input  wire logic              s_irq_pending,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire logic [BYTE_W-1:0] m_read_data,
    input  wire logic              m_irq_clear,
    input  wire logic [BYTE_W-1:0] m_int_enable,
    input  wire logic [BYTE_W-1:0] m_io_port,
    input  wire logic [BYTE_W-1:0] m_hdma_enable,
    output int                     open_requests,
    output int                     fail_count
);

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              irq_clear;
        logic [BYTE_W-1:0] int_enable;
        logic [BYTE_W-1:0] io_port;
        logic [BYTE_W-1:0] hdma_enable;
    } window_reply_t;

    window_reply_t     owed_replies[$];

    logic [BYTE_W-1:0] ctl_int_enable;
    logic [BYTE_W-1:0] ctl_io_port;
    logic [BYTE_W-1:0] ctl_hdma;
    logic [BYTE_W-1:0] mpy_a;
    logic [WORD_W-1:0] math_result;
    logic [WORD_W-1:0] div_num;
    logic [WORD_W-1:0] div_quot;
    logic [LINE_W-1:0] scanline;
    logic              nmi_latched;
    logic [WORD_W-1:0] joy_word [2];

    initial fail_count = 0;

    task automatic report_mismatch(input string msg);
        $display("checker @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic window_reply_t apply_request(
        input logic [REQ_W-1:0]  req,
        input logic [IDX_W-1:0]  idx,
        input logic [BYTE_W-1:0] wd,
        input logic [LINE_W-1:0] line,
        input logic              port,
        input logic [WORD_W-1:0] word,
        input logic              irq
    );
        window_reply_t     r;
        logic [BYTE_W-1:0] rd;
        logic              clr;
        rd  = '0;
        clr = 1'b0;
        case (req)
            REQ_READ: begin
                case (idx)
                    RD_RDNMI: begin
                        rd = (nmi_latched ? FLAG_BIT7 : 8'h00) | NMI_VERSION;
                        nmi_latched = 1'b0;
                    end
                    RD_TIMEUP: begin
                        rd  = irq ? FLAG_BIT7 : 8'h00;
                        clr = 1'b1;
                    end
                    RD_HVBJOY: rd = (scanline >= VBLANK_LINE) ? FLAG_BIT7 : 8'h00;
                    RD_RDDIVL: rd = div_quot[7:0];
                    RD_RDDIVH: rd = div_quot[15:8];
                    RD_RDMPYL: rd = math_result[7:0];
                    RD_RDMPYH: rd = math_result[15:8];
                    RD_JOY1L:  rd = joy_word[0][7:0];
                    RD_JOY1H:  rd = joy_word[0][15:8];
                    RD_JOY2L:  rd = joy_word[1][7:0];
                    RD_JOY2H:  rd = joy_word[1][15:8];
                    default: ;
                endcase
            end
            REQ_WRITE: begin
                case (idx)
                    WR_NMITIMEN: ctl_int_enable = wd;
                    WR_WRIO:     ctl_io_port = wd;
                    WR_WRMPYA:   mpy_a = wd;
                    WR_WRMPYB: begin
                        math_result = WORD_W'(mpy_a) * WORD_W'(wd);
                    end
                    WR_WRDIVL:   div_num[7:0] = wd;
                    WR_WRDIVH:   div_num[15:8] = wd;
                    WR_WRDIVB: begin
                        if (wd != 8'h00) begin
                            div_quot    = div_num / WORD_W'(wd);
                            math_result = div_num % WORD_W'(wd);
                        end else begin
                            div_quot    = DIV_ZERO_Q;
                            math_result = div_num;
                        end
                    end
                    WR_HDMAEN:   ctl_hdma = wd;
                    default: ;
                endcase
            end
            REQ_LINE: begin
                scanline = line;
                if (line == '0) nmi_latched = 1'b0;
            end
            REQ_VBLANK: begin
                nmi_latched = 1'b1;
                scanline    = VBLANK_LINE;
            end
            REQ_PAD: joy_word[port] = word;
            default: ;
        endcase
        r.read_data   = rd;
        r.irq_clear   = clr;
        r.int_enable  = ctl_int_enable;
        r.io_port     = ctl_io_port;
        r.hdma_enable = ctl_hdma;
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        window_reply_t got;
        window_reply_t want;
        if (!aresetn) begin
            ctl_int_enable = '0;
            ctl_io_port    = IO_RESET;
            ctl_hdma       = '0;
            mpy_a          = '0;
            math_result    = '0;
            div_num        = '0;
            div_quot       = '0;
            scanline       = '0;
            nmi_latched    = 1'b0;
            joy_word[0]    = '0;
            joy_word[1]    = '0;
            owed_replies.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_read_data, m_irq_clear, m_int_enable, m_io_port, m_hdma_enable};
                if (owed_replies.size() == 0) begin
                    report_mismatch("reply with no request outstanding");
                end else begin
                    want = owed_replies.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch($sformatf("read_data got %02h expected %02h",
                                                  got.read_data, want.read_data));
                    if (got.irq_clear !== want.irq_clear)
                        report_mismatch($sformatf("irq_clear got %0b expected %0b",
                                                  got.irq_clear, want.irq_clear));
                    if (got.int_enable !== want.int_enable)
                        report_mismatch($sformatf("int_enable got %02h expected %02h",
                                                  got.int_enable, want.int_enable));
                    if (got.io_port !== want.io_port)
                        report_mismatch($sformatf("io_port got %02h expected %02h",
                                                  got.io_port, want.io_port));
                    if (got.hdma_enable !== want.hdma_enable)
                        report_mismatch($sformatf("hdma_enable got %02h expected %02h",
                                                  got.hdma_enable, want.hdma_enable));
                end
            end
            if (s_valid && s_ready) begin
                owed_replies.push_back(apply_request(s_req_type, s_reg_index, s_write_data,
                                                     s_line_number, s_pad_port, s_pad_word,
                                                     s_irq_pending));
            end
        end
        open_requests <= owed_replies.size();
    end

endmodule

`default_nettype wire

// ===== sim/tb_cpu_io_math_registers.sv =====
// ----------------------------------------------------------------------------
// tb_cpu_io_math_registers
// Drives bus reads and writes, scanline, vblank, joypad and unused request types
// into the CPU I/O register window: a directed opening, a long receiver hold-off,
// then random request sequences, with bursty sending and a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cpu_io_math_registers;
    import cior_pkg::*;

    localparam int N_REQUESTS  = 1950;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;

    localparam logic [IDX_W-1:0] WR_DMA_START = 5'h0B;
    localparam logic [IDX_W-1:0] RD_UNMAPPED  = 5'h1F;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [REQ_W-1:0]  s_req_type    = '0;
    logic [IDX_W-1:0]  s_reg_index   = '0;
    logic [BYTE_W-1:0] s_write_data  = '0;
    logic [LINE_W-1:0] s_line_number = '0;
    logic              s_pad_port    = 1'b0;
    logic [WORD_W-1:0] s_pad_word    = '0;
    logic              s_irq_pending = 1'b0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic [BYTE_W-1:0] m_read_data;
    logic              m_irq_clear;
    logic [BYTE_W-1:0] m_int_enable;
    logic [BYTE_W-1:0] m_io_port;
    logic [BYTE_W-1:0] m_hdma_enable;

    int   open_requests;
    int   fail_count;
    int   requests_sent = 0;
    int   burst_left    = 1;
    int   cycle_count   = 0;
    logic steady        = 1'b0;
    logic long_hold     = 1'b0;

    always #1 aclk = ~aclk;

    cpu_io_math_registers dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_reg_index   (s_reg_index),
        .s_write_data  (s_write_data),
        .s_line_number (s_line_number),
        .s_pad_port    (s_pad_port),
        .s_pad_word    (s_pad_word),
        .s_irq_pending (s_irq_pending),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_irq_clear   (m_irq_clear),
        .m_int_enable  (m_int_enable),
        .m_io_port     (m_io_port),
        .m_hdma_enable (m_hdma_enable)
    );

    cpu_io_math_registers_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_reg_index   (s_reg_index),
        .s_write_data  (s_write_data),
        .s_line_number (s_line_number),
        .s_pad_port    (s_pad_port),
        .s_pad_word    (s_pad_word),
        .s_irq_pending (s_irq_pending),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_irq_clear   (m_irq_clear),
        .m_int_enable  (m_int_enable),
        .m_io_port     (m_io_port),
        .m_hdma_enable (m_hdma_enable),
        .open_requests (open_requests),
        .fail_count    (fail_count)
    );

    task automatic offer(
        input logic [REQ_W-1:0]  req,
        input logic [IDX_W-1:0]  idx,
        input logic [BYTE_W-1:0] wd,
        input logic [LINE_W-1:0] line,
        input logic              port,
        input logic [WORD_W-1:0] word,
        input logic              irq
    );
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_reg_index   <= idx;
        s_write_data  <= wd;
        s_line_number <= line;
        s_pad_port    <= port;
        s_pad_word    <= word;
        s_irq_pending <= irq;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        if (!steady) begin
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                // some bursts run straight into the next one
                if ($urandom_range(0, 4) != 0) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge aclk);
                end
            end
        end
    endtask

    task automatic bus_wr(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] d);
        offer(REQ_WRITE, idx, d, LINE_W'($urandom()), 1'($urandom()), WORD_W'($urandom()),
              1'($urandom()));
    endtask

    task automatic bus_rd(input logic [IDX_W-1:0] idx);
        offer(REQ_READ, idx, BYTE_W'($urandom()), LINE_W'($urandom()), 1'($urandom()),
              WORD_W'($urandom()), 1'($urandom()));
    endtask

    task automatic set_line(input logic [LINE_W-1:0] line);
        offer(REQ_LINE, IDX_W'($urandom()), BYTE_W'($urandom()), line, 1'($urandom()),
              WORD_W'($urandom()), 1'($urandom()));
    endtask

    task automatic start_vblank();
        offer(REQ_VBLANK, IDX_W'($urandom()), BYTE_W'($urandom()), LINE_W'($urandom()),
              1'($urandom()), WORD_W'($urandom()), 1'($urandom()));
    endtask

    task automatic set_pad(input logic port, input logic [WORD_W-1:0] word);
        offer(REQ_PAD, IDX_W'($urandom()), BYTE_W'($urandom()), LINE_W'($urandom()), port,
              word, 1'($urandom()));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (open_requests != 0);
    endtask

    task automatic random_sequence();
        int          pick;
        logic [15:0] num;
        logic [7:0]  den;
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            // multiply, sometimes without reloading operand a
            if ($urandom_range(0, 5) != 0) bus_wr(WR_WRMPYA, BYTE_W'($urandom()));
            bus_wr(WR_WRMPYB, BYTE_W'($urandom()));
            bus_rd(RD_RDMPYL);
            bus_rd(RD_RDMPYH);
            if ($urandom_range(0, 3) == 0) bus_rd(RD_RDDIVL);
        end else if (pick < 38) begin
            num = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 300)) : 16'($urandom());
            case ($urandom_range(0, 9))
                0:       den = 8'h00;
                1, 2:    den = 8'($urandom_range(1, 4));
                default: den = 8'($urandom());
            endcase
            if ($urandom_range(0, 7) != 0) bus_wr(WR_WRDIVL, num[7:0]);
            if ($urandom_range(0, 7) != 0) bus_wr(WR_WRDIVH, num[15:8]);
            bus_wr(WR_WRDIVB, den);
            bus_rd(RD_RDDIVL);
            bus_rd(RD_RDDIVH);
            bus_rd(RD_RDMPYL);
            bus_rd(RD_RDMPYH);
        end else if (pick < 50) begin
            start_vblank();
            bus_rd(RD_HVBJOY);
            bus_rd(RD_RDNMI);
            bus_rd(RD_RDNMI);
            if ($urandom_range(0, 1) == 0) set_line('0);
        end else if (pick < 60) begin
            case ($urandom_range(0, 3))
                0:       set_line('0);
                1:       set_line(LINE_W'(VBLANK_LINE - 1 + $urandom_range(0, 2)));
                default: set_line(LINE_W'($urandom()));
            endcase
            bus_rd(RD_HVBJOY);
            bus_rd(RD_RDNMI);
        end else if (pick < 68) begin
            set_pad(1'($urandom()), WORD_W'($urandom()));
            bus_rd(RD_JOY1L);
            bus_rd(RD_JOY1H);
            bus_rd(RD_JOY2L);
            bus_rd(RD_JOY2H);
        end else if (pick < 76) begin
            case ($urandom_range(0, 3))
                0:       bus_wr(WR_NMITIMEN, BYTE_W'($urandom()));
                1:       bus_wr(WR_WRIO, BYTE_W'($urandom()));
                2:       bus_wr(WR_HDMAEN, BYTE_W'($urandom()));
                default: bus_wr(WR_DMA_START, BYTE_W'($urandom()));
            endcase
        end else if (pick < 82) begin
            bus_rd(RD_TIMEUP);
        end else if (pick < 88) begin
            bus_rd(IDX_W'($urandom()));
        end else if (pick < 94) begin
            bus_wr(IDX_W'($urandom()), BYTE_W'($urandom()));
        end else begin
            offer(REQ_W'($urandom()), IDX_W'($urandom()), BYTE_W'($urandom()),
                  LINE_W'($urandom()), 1'($urandom()), WORD_W'($urandom()),
                  1'($urandom()));
        end
    endtask

    // receiver: stall pattern changes per segment, long hold on request
    initial begin : receiver
        int seg_left;
        int mode;
        int period;
        int duty;
        int hold_left;
        int cyc;
        seg_left  = 0;
        hold_left = 0;
        cyc       = 0;
        mode      = 0;
        period    = 2;
        duty      = 1;
        forever begin
            @(posedge aclk);
            cyc++;
            if (long_hold) hold_left = HOLD_CYCLES;
            if (seg_left == 0) begin
                seg_left = $urandom_range(16, 128);
                mode     = $urandom_range(0, 3);
                period   = $urandom_range(2, 9);
                duty     = $urandom_range(1, period - 1);
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0, 1:    m_ready <= 1'b1;
                    2:       m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ((cyc % period) < duty);
                endcase
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("cpu_io_math_registers: mismatch");
        $finish;
    end

    initial begin : stimulus
        int t;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values, flag reads and unmapped offsets
        bus_rd(RD_RDNMI);
        offer(REQ_READ, RD_TIMEUP, 8'h00, '0, 1'b0, '0, 1'b1);
        bus_rd(RD_HVBJOY);
        bus_rd(RD_UNMAPPED);
        bus_wr(WR_NMITIMEN, 8'hFF);
        bus_wr(WR_WRIO, 8'h00);
        bus_wr(WR_HDMAEN, 8'hFF);
        bus_wr(WR_DMA_START, 8'h55);
        // largest product
        bus_wr(WR_WRMPYA, 8'hFF);
        bus_wr(WR_WRMPYB, 8'hFF);
        bus_rd(RD_RDMPYH);
        // divide by zero, then by one
        bus_wr(WR_WRDIVL, 8'hFF);
        bus_wr(WR_WRDIVH, 8'hFF);
        bus_wr(WR_WRDIVB, 8'h00);
        bus_rd(RD_RDDIVH);
        bus_rd(RD_RDMPYL);
        bus_wr(WR_WRDIVB, 8'h01);
        bus_rd(RD_RDDIVL);
        // vblank latch, read clears it, scanline zero
        start_vblank();
        bus_rd(RD_RDNMI);
        bus_rd(RD_RDNMI);
        set_line('0);
        set_pad(1'b1, 16'hFFFF);
        bus_rd(RD_JOY2H);
        for (t = REQ_PAD + 1; t < (1 << REQ_W); t++) begin
            offer(REQ_W'(t), IDX_W'($urandom()), BYTE_W'($urandom()), LINE_W'($urandom()),
                  1'($urandom()), WORD_W'($urandom()), 1'b1);
        end
        drain();

        // receiver holds off while requests keep coming
        long_hold <= 1'b1;
        @(posedge aclk);
        long_hold <= 1'b0;
        steady = 1'b1;
        repeat (10) random_sequence();
        steady = 1'b0;

        while (requests_sent < N_REQUESTS) begin
            random_sequence();
            if ($urandom_range(0, 49) == 0) drain();
            if (requests_sent > N_REQUESTS / 2 && requests_sent < N_REQUESTS / 2 + 4) begin
                drain();
                long_hold <= 1'b1;
                @(posedge aclk);
                long_hold <= 1'b0;
                steady = 1'b1;
                repeat (8) random_sequence();
                steady = 1'b0;
            end
        end

        drain();
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("cpu_io_math_registers: match");
        end else begin
            $display("cpu_io_math_registers: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/cior_pkg.sv
hdl/cpu_io_math_registers.sv
sim/cpu_io_math_registers_checker.sv
sim/tb_cpu_io_math_registers.sv
